// ===== design/bpa_pkg.sv =====
package bpa_pkg;

    localparam int PAGES          = 65536;
    localparam int RESERVED_PAGES = 256;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = $clog2(WORD_W);
    localparam int MAP_WORDS      = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W        = $clog2(MAP_WORDS);
    localparam int CNT_W          = WADDR_W + 1;
    localparam int PAGE_W         = 16;
    localparam int LEN_W          = 17;
    // wide enough for page + length and for PAGES itself
    localparam int SPAN_W         = ($clog2(PAGES) + 1 > LEN_W + 1) ?
                                    $clog2(PAGES) + 1 : LEN_W + 1;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_TEST,
        OP_RESERVE
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PREP,
        ST_TEST,
        ST_SCAN,
        ST_SWEEP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic init_wr;
        logic load;
        logic adv;
        logic wr;
        logic scan;
        logic fail;
        logic test_take;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        op_t  op;
        logic len_zero;
        logic sweep_empty;
        logic issue_done;
        logic pipe_valid;
        logic hit;
    } sts_t;

endpackage

// ===== design/bpa_datapath.sv =====
module bpa_datapath
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [1:0]        op,
    input  logic [PAGE_W-1:0] page_index,
    input  logic [LEN_W-1:0]  run_length,
    output logic              ok,
    output logic [PAGE_W-1:0] first_page,
    output logic              page_used
);

    localparam logic [SPAN_W-1:0] PAGES_S  = SPAN_W'(PAGES);
    localparam logic [SPAN_W-1:0] RES_HI_S = (RESERVED_PAGES < PAGES) ?
                                             SPAN_W'(RESERVED_PAGES) : SPAN_W'(PAGES);

    logic [WORD_W-1:0]  mem [MAP_WORDS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [WADDR_W-1:0] init_cnt_reg;
    logic [CNT_W-1:0]   addr_cnt_reg;
    logic [CNT_W-1:0]   end_cnt_reg;
    logic               pipe_valid_reg;
    logic [WADDR_W-1:0] pipe_addr_reg;
    logic [SPAN_W-1:0]  lo_reg;
    logic [SPAN_W-1:0]  hi_reg;
    logic [LEN_W-1:0]   len_reg;
    op_t                op_reg;
    logic               set_reg;
    logic [SPAN_W-1:0]  run_reg;
    logic               fail_reg;
    logic               used_reg;
    logic               ok_reg;
    logic [PAGE_W-1:0]  first_reg;
    logic               page_used_reg;

    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  init_mask;
    logic [WORD_W-1:0]  rmw_mask;
    logic [SPAN_W-1:0]  page_ext;
    logic [SPAN_W-1:0]  hi_raw;
    logic [SPAN_W-1:0]  hi_clamp;
    logic [SPAN_W-1:0]  hi_m1;
    logic [SPAN_W-1:0]  run_vec [WORD_W];
    logic [WORD_W-1:0]  fit_vec;
    logic [BIT_W-1:0]   fit_pos;
    logic [SPAN_W-1:0]  hit_end;
    logic [SPAN_W-1:0]  hit_lo;
    logic               hit;

    // bits of the word at base that fall in [lo, hi)
    function automatic logic [WORD_W-1:0] word_mask(input logic [SPAN_W-1:0] base,
                                                    input logic [SPAN_W-1:0] lo,
                                                    input logic [SPAN_W-1:0] hi);
        logic [SPAN_W-1:0] dl;
        logic [SPAN_W-1:0] dh;
        logic [WORD_W-1:0] ml;
        logic [WORD_W-1:0] mh;
        dl = lo - base;
        dh = hi - base;
        if (lo <= base)
            ml = '1;
        else if (dl >= SPAN_W'(WORD_W))
            ml = '0;
        else
            ml = {WORD_W{1'b1}} << dl[BIT_W-1:0];
        if (hi <= base)
            mh = '0;
        else if (dh >= SPAN_W'(WORD_W))
            mh = '1;
        else
            mh = ~({WORD_W{1'b1}} << dh[BIT_W-1:0]);
        return ml & mh;
    endfunction

    assign init_mask = word_mask(SPAN_W'({init_cnt_reg, BIT_W'(0)}), '0, RES_HI_S);
    assign rmw_mask  = word_mask(SPAN_W'({pipe_addr_reg, BIT_W'(0)}), lo_reg, hi_reg);

    always_comb
    begin
        wr_en   = cmd.init_wr | (cmd.wr & pipe_valid_reg);
        wr_addr = cmd.init_wr ? init_cnt_reg : pipe_addr_reg;
        if (cmd.init_wr)
            wr_data = init_mask;
        else if (set_reg)
            wr_data = rd_data_reg | rmw_mask;
        else
            wr_data = rd_data_reg & ~rmw_mask;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[addr_cnt_reg[WADDR_W-1:0]];
    end

    // free run ending at each bit of the word under scan
    always_comb
    begin
        logic             any;
        logic [BIT_W-1:0] hs;
        for (int j = 0; j < WORD_W; j++)
        begin
            any = 1'b0;
            hs  = '0;
            for (int b = 0; b <= j; b++)
            begin
                if (rd_data_reg[b])
                begin
                    any = 1'b1;
                    hs  = BIT_W'(b);
                end
            end
            run_vec[j] = any ? (SPAN_W'(j) - SPAN_W'(hs)) : (run_reg + SPAN_W'(j + 1));
            fit_vec[j] = run_vec[j] >= SPAN_W'(len_reg);
        end
        fit_pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (fit_vec[j])
                fit_pos = BIT_W'(j);
        end
    end

    assign hit     = pipe_valid_reg & (|fit_vec);
    assign hit_end = SPAN_W'({pipe_addr_reg, fit_pos});
    assign hit_lo  = hit_end + SPAN_W'(1) - SPAN_W'(len_reg);

    always_comb
    begin
        page_ext = SPAN_W'(page_index);
        if (op_t'(op) == OP_RESERVE)
            hi_raw = page_ext + SPAN_W'(1);
        else
            hi_raw = page_ext + SPAN_W'(run_length);
        hi_clamp = (hi_raw > PAGES_S) ? PAGES_S : hi_raw;
        hi_m1    = hi_clamp - SPAN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg   <= '0;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_wr)
                init_cnt_reg <= init_cnt_reg + WADDR_W'(1);
            pipe_valid_reg <= cmd.adv;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= addr_cnt_reg[WADDR_W-1:0];
        if (cmd.load)
        begin
            lo_reg   <= page_ext;
            hi_reg   <= hi_clamp;
            len_reg  <= run_length;
            op_reg   <= op_t'(op);
            set_reg  <= (op_t'(op) == OP_RESERVE);
            run_reg  <= '0;
            fail_reg <= 1'b0;
            used_reg <= 1'b0;
            if (op_t'(op) == OP_ALLOC)
            begin
                addr_cnt_reg <= '0;
                end_cnt_reg  <= CNT_W'(MAP_WORDS);
            end
            else
            begin
                addr_cnt_reg <= page_ext[BIT_W +: CNT_W];
                end_cnt_reg  <= hi_m1[BIT_W +: CNT_W] + CNT_W'(1);
            end
        end
        else if (cmd.scan && hit)
        begin
            // switch to marking the found run used
            lo_reg       <= hit_lo;
            hi_reg       <= hit_end + SPAN_W'(1);
            set_reg      <= 1'b1;
            addr_cnt_reg <= hit_lo[BIT_W +: CNT_W];
            end_cnt_reg  <= hit_end[BIT_W +: CNT_W] + CNT_W'(1);
        end
        else
        begin
            if (cmd.adv)
                addr_cnt_reg <= addr_cnt_reg + CNT_W'(1);
            if (cmd.scan && pipe_valid_reg)
                run_reg <= run_vec[WORD_W-1];
        end
        if (cmd.fail)
            fail_reg <= 1'b1;
        if (cmd.test_take)
            used_reg <= (lo_reg < PAGES_S) & rd_data_reg[lo_reg[BIT_W-1:0]];
        if (cmd.out_load)
        begin
            ok_reg        <= ~fail_reg;
            first_reg     <= (op_reg == OP_ALLOC && !fail_reg) ? lo_reg[PAGE_W-1:0] : '0;
            page_used_reg <= used_reg;
        end
    end

    always_comb
    begin
        sts.init_last   = (init_cnt_reg == WADDR_W'(MAP_WORDS - 1));
        sts.op          = op_reg;
        sts.len_zero    = (len_reg == '0);
        sts.sweep_empty = (lo_reg >= hi_reg);
        sts.issue_done  = (addr_cnt_reg == end_cnt_reg);
        sts.pipe_valid  = pipe_valid_reg;
        sts.hit         = hit;
    end

    assign ok         = ok_reg;
    assign first_page = first_reg;
    assign page_used  = page_used_reg;

endmodule

// ===== design/bpa_ctrl.sv =====
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                unique case (sts.op)
                    OP_ALLOC:
                    begin
                        if (sts.len_zero)
                        begin
                            cmd.fail   = 1'b1;
                            state_next = ST_FIN;
                        end
                        else
                            state_next = ST_SCAN;
                    end
                    OP_TEST:
                        state_next = ST_TEST;
                    default:
                        state_next = sts.sweep_empty ? ST_FIN : ST_SWEEP;
                endcase
            end
            ST_TEST:
            begin
                cmd.test_take = 1'b1;
                state_next    = ST_FIN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd.adv  = ~sts.issue_done & ~sts.hit;
                if (sts.hit)
                    state_next = ST_SWEEP;
                else if (sts.issue_done && !sts.pipe_valid)
                begin
                    cmd.fail   = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_SWEEP:
            begin
                cmd.wr  = 1'b1;
                cmd.adv = ~sts.issue_done;
                if (sts.issue_done && !sts.pipe_valid)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/bitmap_page_allocator.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | op, page_index, run_length
// out     | out_valid / out_stall| ok, first_page, page_used
//
// One request at a time. Test reads the bitmap word that holds the page;
// free and reserve read, modify and write each bitmap word the run touches,
// and skip that sweep when the run is empty; allocate scans one 32-bit
// bitmap word per cycle from word 0 (up to 2048) and then marks the run one
// word per cycle. The bitmap memory has one write port and one read port.
// After reset a pass over all 2048 words writes the initial bitmap; input is stalled.
// A new request is taken while the previous result waits on out_stall.
module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [PAGE_W-1:0] page_index,
    input  logic [LEN_W-1:0]  run_length,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [PAGE_W-1:0] first_page,
    output logic              page_used
);

    cmd_t cmd;
    sts_t sts;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .op         (op),
        .page_index (page_index),
        .run_length (run_length),
        .ok         (ok),
        .first_page (first_page),
        .page_used  (page_used)
    );

endmodule

// ===== design/bpa_checker.sv =====
module bpa_assertions
    import bpa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              ok,
    input logic [PAGE_W-1:0] first_page,
    input logic              page_used
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({ok, first_page, page_used}))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> first_page == '0 && !page_used)
        else $error("failed allocation carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && page_used |-> ok && first_page == '0)
        else $error("test result mixed with allocation data");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

endmodule

bind bitmap_page_allocator bpa_assertions u_bpa_assertions (.*);

// ===== tb/bpa_checker.sv =====
module bpa_checker
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        op,
    input  logic [PAGE_W-1:0] page_index,
    input  logic [LEN_W-1:0]  run_length,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              ok,
    input  logic [PAGE_W-1:0] first_page,
    input  logic              page_used,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] first_page;
        logic              page_used;
    } reply_t;

    logic   page_map [PAGES];
    reply_t reply_q[$];

    assign pending = reply_q.size();

    function automatic reply_t serve_request(op_t req, int unsigned pg, int unsigned len);
        reply_t r;
        int unsigned start;
        int unsigned run;
        bit found;
        r = '{ok: 1'b1, first_page: '0, page_used: 1'b0};
        start = 0;
        run = 0;
        found = 0;
        case (req)
            OP_ALLOC:
            begin
                if (len != 0)
                begin
                    for (int unsigned i = 0; i < PAGES; i++)
                    begin
                        if (!page_map[i])
                        begin
                            run++;
                            if (run == len)
                            begin
                                found = 1;
                                break;
                            end
                        end
                        else
                        begin
                            run = 0;
                            start = i + 1;
                        end
                    end
                end
                if (found)
                begin
                    for (int unsigned i = 0; i < len; i++)
                        page_map[start + i] = 1'b1;
                    r.first_page = start[PAGE_W-1:0];
                end
                else
                    r.ok = 1'b0;
            end
            OP_FREE:
            begin
                // pages past the end drop; no wrap
                for (int unsigned i = 0; i < len; i++)
                    if (pg + i < PAGES)
                        page_map[pg + i] = 1'b0;
            end
            OP_TEST:
                r.page_used = (pg < PAGES) ? page_map[pg] : 1'b0;
            default:
                if (pg < PAGES)
                    page_map[pg] = 1'b1;
        endcase
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < PAGES; i++)
            page_map[i] = (i < RESERVED_PAGES);
    end

    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
            fail_count <= 0;
        else
        begin
            if (in_valid && !in_stall)
                reply_q.push_back(serve_request(op_t'(op), page_index, run_length));
            if (out_valid && !out_stall)
            begin
                got = '{ok: ok, first_page: first_page, page_used: page_used};
                if (reply_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result ok=%0b first=%0d used=%0b",
                                 ok, first_page, page_used);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch exp ok=%0b first=%0d used=%0b, got ok=%0b first=%0d used=%0b",
                                     want.ok, want.first_page, want.page_used,
                                     ok, first_page, page_used);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_bitmap_page_allocator.sv =====
module tb_bitmap_page_allocator
    import bpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 40000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        op;
    logic [PAGE_W-1:0] page_index;
    logic [LEN_W-1:0]  run_length;
    logic              out_valid;
    logic              out_stall;
    logic              ok;
    logic [PAGE_W-1:0] first_page;
    logic              page_used;
    int                fail_count;
    int                pending;
    int                quiet_cycles;
    bit                long_hold;
    bit                hold_done;

    bitmap_page_allocator i_dut (.*);

    bpa_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_request(op_t req, int unsigned pg, int unsigned len);
        int unsigned gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= req;
        page_index <= pg[PAGE_W-1:0];
        run_length <= len[LEN_W-1:0];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned pick_len();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 131071);
            2:       return $urandom_range(33, 300);
            default: return $urandom_range(1, 32);
        endcase
    endfunction

    function automatic int unsigned pick_page();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 65535);
            1:       return $urandom_range(65400, 65535);
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // receiver: random stall per transfer, plus one long hold
    initial
    begin
        int unsigned gap;
        out_stall <= 1'b1;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                gap = $urandom_range(0, 4);
                if (gap != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
                out_stall <= 1'b0;
                do
                    @(posedge clk);
                while (!out_valid && !(long_hold && !hold_done));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("tb_bitmap_page_allocator failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        op         <= OP_ALLOC;
        page_index <= '0;
        run_length <= '0;
        long_hold  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_request(OP_TEST, 0, 0);
        send_request(OP_TEST, 255, 0);
        send_request(OP_TEST, 256, 0);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 12345, 1);
        send_request(OP_ALLOC, 0, 65536);
        send_request(OP_ALLOC, 0, 131071);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 0, 300);
        send_request(OP_ALLOC, 65535, 5);
        send_request(OP_TEST, 4, 0);
        send_request(OP_FREE, 65530, 100);
        send_request(OP_TEST, 65535, 131071);
        send_request(OP_RESERVE, 65535, 0);
        send_request(OP_RESERVE, 65535, 99);
        send_request(OP_TEST, 65535, 0);
        send_request(OP_RESERVE, 3, 0);
        send_request(OP_ALLOC, 0, 3);
        send_request(OP_FREE, 0, 131071);
        send_request(OP_ALLOC, 0, 65536);
        send_request(OP_TEST, 40000, 0);
        send_request(OP_FREE, 0, 65536);
        send_request(OP_RESERVE, 0, 0);
        send_request(OP_ALLOC, 0, 65535);

        // pause until every result is back
        wait_drained();

        long_hold = 1;
        for (int n = 0; n < 12; n++)
            send_request(op_t'($urandom_range(1, 3)), pick_page(), pick_len());

        for (int n = 0; n < 250; n++)
        begin
            if (n == 140)
            begin
                wait_drained();
                send_request(OP_FREE, 0, 65536);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_request(OP_ALLOC, $urandom_range(0, 65535), pick_len());
                4, 5:       send_request(OP_FREE, pick_page(), pick_len());
                6, 7:       send_request(OP_TEST, pick_page(), $urandom_range(0, 131071));
                default:    send_request(OP_RESERVE, pick_page(), $urandom_range(0, 131071));
            endcase
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("tb_bitmap_page_allocator passed");
        else
            $display("tb_bitmap_page_allocator failed");
        $finish;
    end
endmodule
